@@ hw/rtl/afrr_pkg.sv @@
`default_nettype none

package afrr_pkg;

  localparam int unsigned FrameLen    = 29;
  localparam int unsigned ReqLen      = 5;
  localparam logic [7:0]  ChStx       = 8'h02;
  localparam logic [7:0]  ChEtx       = 8'h03;
  localparam logic [7:0]  ChZero      = 8'h30;
  localparam logic [7:0]  ChOne       = 8'h31;
  localparam logic [7:0]  TimeoutRst  = 8'd100;
  localparam logic [2:0]  MaxChanRst  = 3'd1;

  localparam int unsigned PaddrW      = 3;
  localparam int unsigned PdataW      = 32;

  typedef enum logic [1:0] {
    ActStart = 2'd0,
    ActByte  = 2'd1,
    ActTick  = 2'd2,
    ActNone  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    StOk      = 3'd0,
    StBadChan = 3'd1,
    StTimeout = 3'd2,
    StChksum  = 3'd3,
    StFormat  = 3'd4,
    StBadHex  = 3'd5
  } status_e;

  typedef enum logic {
    RegTimeout = 1'b0,
    RegMaxChan = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [1:0] action;
    logic [2:0] channel;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  tx_byte;
    logic [11:0] reading;
    status_e     status;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [7:0] timeout_ticks;
    logic [2:0] max_channel;
  } cfg_t;

  // what one processed request leaves for the output side
  typedef struct packed {
    logic        has;
    logic        req;
    status_e     status;
    logic [11:0] reading;
  } res_desc_t;

  function automatic logic [7:0] req_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = ChStx;
      3'd1:    b = ChZero;
      3'd2:    b = ChOne;
      3'd3:    b = ChEtx;
      3'd4:    b = 8'h66;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // {invalid, value}
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, c[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b0, c[3:0] + 4'd9};
    end else begin
      r = 5'h10;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/afrr_regs.sv @@
`default_nettype none

module afrr_regs (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [afrr_pkg::PaddrW-1:0]      paddr,
  input  wire logic [afrr_pkg::PdataW-1:0]      pwdata,
  output logic      [afrr_pkg::PdataW-1:0]      prdata,
  output afrr_pkg::cfg_t                        cfg_o
);

  logic [7:0] timeout_q, timeout_d;
  logic [2:0] max_chan_q, max_chan_d;
  logic       wr_en;
  afrr_pkg::reg_idx_e sel;

  assign sel   = afrr_pkg::reg_idx_e'(paddr[2]);
  assign wr_en = psel && penable && pwrite;

  always_comb begin
    timeout_d  = timeout_q;
    max_chan_d = max_chan_q;
    if (wr_en) begin
      case (sel)
        afrr_pkg::RegTimeout: timeout_d  = pwdata[7:0];
        afrr_pkg::RegMaxChan: max_chan_d = pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q  <= afrr_pkg::TimeoutRst;
      max_chan_q <= afrr_pkg::MaxChanRst;
    end else begin
      timeout_q  <= timeout_d;
      max_chan_q <= max_chan_d;
    end
  end

  always_comb begin
    case (sel)
      afrr_pkg::RegTimeout: prdata = {{(afrr_pkg::PdataW-8){1'b0}}, timeout_q};
      afrr_pkg::RegMaxChan: prdata = {{(afrr_pkg::PdataW-3){1'b0}}, max_chan_q};
      default:              prdata = '0;
    endcase
  end

  assign cfg_o.timeout_ticks = timeout_q;
  assign cfg_o.max_channel   = max_chan_q;

endmodule

`default_nettype wire

@@ hw/rtl/afrr_core.sv @@
`default_nettype none

module afrr_core (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire afrr_pkg::in_item_t   item_i,
  input  wire logic                 take_i,
  input  wire afrr_pkg::cfg_t       cfg_i,
  output afrr_pkg::res_desc_t       desc_o
);

  logic        phase_q, phase_d;
  logic [4:0]  byte_count_q, byte_count_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  tick_q, tick_d;
  logic [2:0]  chan_q, chan_d;
  logic [11:0] digits_q, digits_d;
  logic        format_ok_q, format_ok_d;
  logic        digits_ok_q, digits_ok_d;

  logic [5:0]  first_pos;
  logic [5:0]  pos;
  logic [4:0]  hex;
  logic [7:0]  tick_inc;
  logic [7:0]  b;
  logic        bad_fmt;

  assign b         = item_i.rx_byte;
  assign pos       = {1'b0, byte_count_q};
  assign first_pos = ({3'b000, chan_q} << 1) + {3'b000, chan_q} + 6'd3;
  assign hex       = afrr_pkg::hex_value(b);
  assign tick_inc  = tick_q + 8'd1;
  assign bad_fmt   = (byte_count_q == 5'd0  && b != afrr_pkg::ChStx)
                  || (byte_count_q == 5'd1  && b != afrr_pkg::ChZero)
                  || (byte_count_q == 5'd2  && b != afrr_pkg::ChOne)
                  || (byte_count_q == 5'd27 && b != afrr_pkg::ChEtx);

  always_comb begin
    phase_d      = phase_q;
    byte_count_d = byte_count_q;
    sum_d        = sum_q;
    tick_d       = tick_q;
    chan_d       = chan_q;
    digits_d     = digits_q;
    format_ok_d  = format_ok_q;
    digits_ok_d  = digits_ok_q;
    desc_o       = '0;

    case (afrr_pkg::action_e'(item_i.action))
      afrr_pkg::ActStart: begin
        desc_o.has = 1'b1;
        if (item_i.channel > cfg_i.max_channel) begin
          desc_o.status = afrr_pkg::StBadChan;
        end else begin
          desc_o.req   = 1'b1;
          phase_d      = 1'b1;
          chan_d       = item_i.channel;
          byte_count_d = '0;
          sum_d        = '0;
          tick_d       = '0;
          digits_d     = '0;
          format_ok_d  = 1'b1;
          digits_ok_d  = 1'b1;
        end
      end
      afrr_pkg::ActByte: begin
        if (phase_q) begin
          if (byte_count_q < 5'(afrr_pkg::FrameLen - 1)) begin
            sum_d        = sum_q + b;
            byte_count_d = byte_count_q + 5'd1;
            if (bad_fmt) format_ok_d = 1'b0;
            if (pos >= first_pos && pos < first_pos + 6'd3) begin
              if (hex[4]) digits_ok_d = 1'b0;
              digits_d = {digits_q[7:0], hex[4] ? 4'h0 : hex[3:0]};
            end
          end else begin
            desc_o.has = 1'b1;
            if (sum_q != b) begin
              desc_o.status = afrr_pkg::StChksum;
            end else if (!format_ok_q) begin
              desc_o.status = afrr_pkg::StFormat;
            end else if (!digits_ok_q) begin
              desc_o.status = afrr_pkg::StBadHex;
            end else begin
              desc_o.status  = afrr_pkg::StOk;
              desc_o.reading = digits_q;
            end
            phase_d      = 1'b0;
            byte_count_d = '0;
            sum_d        = '0;
            tick_d       = '0;
            digits_d     = '0;
            format_ok_d  = 1'b1;
            digits_ok_d  = 1'b1;
          end
        end
      end
      afrr_pkg::ActTick: begin
        if (phase_q) begin
          tick_d = tick_inc;
          // a limit of zero behaves like one
          if (tick_inc >= cfg_i.timeout_ticks || tick_inc == 8'd0) begin
            desc_o.has    = 1'b1;
            desc_o.status = afrr_pkg::StTimeout;
            phase_d       = 1'b0;
            byte_count_d  = '0;
            sum_d         = '0;
            tick_d        = '0;
            digits_d      = '0;
            format_ok_d   = 1'b1;
            digits_ok_d   = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= 1'b0;
      byte_count_q <= '0;
      sum_q        <= '0;
      tick_q       <= '0;
      chan_q       <= '0;
      digits_q     <= '0;
      format_ok_q  <= 1'b1;
      digits_ok_q  <= 1'b1;
    end else if (take_i) begin
      phase_q      <= phase_d;
      byte_count_q <= byte_count_d;
      sum_q        <= sum_d;
      tick_q       <= tick_d;
      chan_q       <= chan_d;
      digits_q     <= digits_d;
      format_ok_q  <= format_ok_d;
      digits_ok_q  <= digits_ok_d;
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_count_q <= 5'(afrr_pkg::FrameLen - 1))
    else $error("byte count past frame end");

  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !phase_q |-> (byte_count_q == 5'd0 && tick_q == 8'd0 && sum_q == 8'd0))
    else $error("frame state not cleared while idle");

  a_result_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_i && desc_o.has && !desc_o.req && desc_o.status != afrr_pkg::StBadChan)
    |=> !phase_q)
    else $error("still waiting after final result");

endmodule

`default_nettype wire

@@ hw/rtl/afrr_out.sv @@
`default_nettype none

module afrr_out (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire afrr_pkg::res_desc_t  desc_i,
  input  wire logic                 load_i,
  output logic                      free_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output afrr_pkg::out_item_t       out_item_o
);

  logic                valid_q, valid_d;
  logic                req_q, req_d;
  logic [2:0]          idx_q, idx_d;
  afrr_pkg::status_e   status_q, status_d;
  logic [11:0]         reading_q, reading_d;
  logic                last;
  logic                pop;

  assign last = req_q ? (idx_q == 3'(afrr_pkg::ReqLen - 1)) : 1'b1;
  assign pop  = valid_q && out_ready_i;
  assign free_o = !valid_q || (out_ready_i && last);

  always_comb begin
    valid_d   = valid_q;
    req_d     = req_q;
    idx_d     = idx_q;
    status_d  = status_q;
    reading_d = reading_q;
    if (pop) begin
      if (last) begin
        valid_d = 1'b0;
      end else begin
        idx_d = idx_q + 3'd1;
      end
    end
    if (load_i) begin
      valid_d   = 1'b1;
      req_d     = desc_i.req;
      idx_d     = '0;
      status_d  = desc_i.status;
      reading_d = desc_i.reading;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      req_q   <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      req_q   <= req_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    reading_q <= reading_d;
  end

  assign out_valid_o        = valid_q;
  assign out_item_o.kind    = !req_q;
  assign out_item_o.tx_byte = req_q ? afrr_pkg::req_byte(idx_q) : 8'h00;
  assign out_item_o.reading = req_q ? 12'h000 : reading_q;
  assign out_item_o.status  = req_q ? afrr_pkg::StOk : status_q;
  assign out_item_o.last    = last;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("result loaded over one still pending");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && req_q |-> idx_q < 3'(afrr_pkg::ReqLen))
    else $error("request byte index out of range");

  a_req_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && req_q && !last && !load_i) |=> (valid_q && idx_q == $past(idx_q) + 3'd1))
    else $error("request byte sequence skipped");

endmodule

`default_nettype wire

@@ hw/rtl/analog_frame_request_receiver_top.sv @@
// Channel   Dir  Handshake                 Payload
// in        in   in_valid_i / in_ready_o   in_item_i  (action, channel, rx_byte)
// out       out  out_valid_o / out_ready_i out_item_o (kind, tx_byte, reading, status, last)
// cfg       in   psel/penable/pwrite/pready paddr, pwdata, prdata (timeout, max channel)
//
// Requests go through an input register, then combinational decode and frame
// update, then an output register. Bytes, ticks and ignored requests with no result
// never wait on the output register; an accepted start holds it until all of its
// request bytes are taken. Reset is asynchronous and clears all control state.
// in_ready_o drops only while the input register holds a request that
// produces results and the output register cannot take them yet.
`default_nettype none

module analog_frame_request_receiver_top (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire afrr_pkg::in_item_t               in_item_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output afrr_pkg::out_item_t                   out_item_o,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [afrr_pkg::PaddrW-1:0]      paddr,
  input  wire logic [afrr_pkg::PdataW-1:0]      pwdata,
  output logic      [afrr_pkg::PdataW-1:0]      prdata,
  output logic                                  pready
);

  afrr_pkg::cfg_t       cfg;
  afrr_pkg::res_desc_t  desc;
  afrr_pkg::in_item_t   in_q;
  logic                 in_valid_q, in_valid_d;
  logic                 advance;
  logic                 out_free;

  assign pready = 1'b1;

  afrr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  assign advance    = in_valid_q && (!desc.has || out_free);
  assign in_ready_o = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (advance) in_valid_d = 1'b0;
    if (in_valid_i && in_ready_o) in_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_q <= in_item_i;
  end

  afrr_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (in_q),
    .take_i (advance),
    .cfg_i  (cfg),
    .desc_o (desc)
  );

  afrr_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .desc_i      (desc),
    .load_i      (advance && desc.has),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire
